// ===== sv/qrs_pkg.sv =====
// shared types and fixed-point constants for the quadratic root solver
// no dependencies; imported by qrs_disc and the top level
package qrs_pkg;

  localparam int NORM_BITS  = 30;
  localparam int NRM_W      = NORM_BITS + 1;
  localparam int LO_W       = 16;
  localparam int HI_W       = NRM_W - LO_W;
  localparam int PROD_W     = 2 * NRM_W;
  localparam int SQRT_W     = PROD_W / 2;
  localparam int BD_W       = NRM_W + 1;
  localparam int OUT_W      = 48;
  localparam int TOL_W      = 16;
  localparam int DISC_SHIFT = 20;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_EXTREMUM = 2'd1,
    STAT_ONE      = 2'd2,
    STAT_TWO      = 2'd3
  } status_t;

  typedef struct packed {
    logic             zero;
    logic             na;
    logic             nc;
    logic [NRM_W-1:0] am;
    logic [NRM_W-1:0] bm;
    logic [NRM_W-1:0] cm;
  } nrm_t;

  typedef struct packed {
    logic kill;
    logic extremum;
    logic zden;
    logic single;
    logic neg0;
  } ctl_t;

endpackage

// ===== sv/qrs_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with side payload
// depends on nothing; used for normalisation and for the root quotients
module qrs_divider #(
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_in,
  input  logic [QUO_W-1:0]  low_in,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_s  [QUO_W+1];
  logic [QUO_W-1:0]  low_s  [QUO_W+1];
  logic [QUO_W-1:0]  quo_s  [QUO_W+1];
  logic [DEN_W-1:0]  den_s  [QUO_W+1];
  logic [SIDE_W-1:0] side_s [QUO_W+1];
  logic              vld_s  [QUO_W+1];

  assign rem_s[0]  = rem_in;
  assign low_s[0]  = low_in;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_s[k-1], low_s[k-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_s[k-1]};
    assign ge    = trial >= {1'b0, den_s[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else if (en) begin
        vld_s[k] <= vld_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_s[k]  <= {low_s[k-1][QUO_W-2:0], 1'b0};
        quo_s[k]  <= {quo_s[k-1][QUO_W-2:0], ge};
        den_s[k]  <= den_s[k-1];
        side_s[k] <= side_s[k-1];
      end
    end
  end

  assign out_valid = vld_s[QUO_W];
  assign quo       = quo_s[QUO_W];
  assign side_out  = side_s[QUO_W];

endmodule

// ===== sv/qrs_isqrt.sv =====
// pipelined floor square root, one root bit per stage, with side payload
// depends on nothing; radicand width must be even
module qrs_isqrt #(
  parameter int RAD_W  = 62,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      rad,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W-1:0]  rem_s  [ROOT_W+1];
  logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
  logic [ROOT_W-1:0] root_s [ROOT_W+1];
  logic [SIDE_W-1:0] side_s [ROOT_W+1];
  logic              vld_s  [ROOT_W+1];

  assign rem_s[0]  = '0;
  assign rad_s[0]  = rad;
  assign root_s[0] = '0;
  assign side_s[0] = side_in;
  assign vld_s[0]  = in_valid;

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    assign shifted = {rem_s[k-1], rad_s[k-1][RAD_W-1:RAD_W-2]};
    assign trial   = {2'b00, root_s[k-1], 2'b01};
    assign diff    = shifted - trial;
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else if (en) begin
        vld_s[k] <= vld_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        rad_s[k]  <= {rad_s[k-1][RAD_W-3:0], 2'b00};
        root_s[k] <= {root_s[k-1][ROOT_W-2:0], ge};
        side_s[k] <= side_s[k-1];
      end
    end
  end

  assign out_valid = vld_s[ROOT_W];
  assign root      = root_s[ROOT_W];
  assign side_out  = side_s[ROOT_W];

endmodule

// ===== sv/qrs_disc.sv =====
// discriminant b*b - a*c from split partial products, tolerance and sign test
// depends on qrs_pkg; four register stages
module qrs_disc (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  qrs_pkg::nrm_t             nrm_in,
  input  logic [qrs_pkg::TOL_W-1:0] tol,
  output logic                      out_valid,
  output logic [qrs_pkg::PROD_W-1:0] rad,
  output logic                      extremum,
  output qrs_pkg::nrm_t             nrm_out
);
  import qrs_pkg::*;

  logic                  v1, v2, v3;
  nrm_t                  n1, n2, n3;
  logic [2*HI_W-1:0]     bb_hh, ac_hh;
  logic [HI_W+LO_W-1:0]  bb_hl, ac_hl, ac_lh;
  logic [2*LO_W-1:0]     bb_ll, ac_ll;
  logic [PROD_W-1:0]     bb, ac;
  logic                  add;
  logic [PROD_W-1:0]     dmag;
  logic                  dneg;
  logic [HI_W+LO_W:0]    ac_mid;
  logic [PROD_W-1:0]     limit;
  logic                  near_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= nrm_in;
      bb_hh <= nrm_in.bm[NRM_W-1:LO_W] * nrm_in.bm[NRM_W-1:LO_W];
      bb_hl <= nrm_in.bm[NRM_W-1:LO_W] * nrm_in.bm[LO_W-1:0];
      bb_ll <= nrm_in.bm[LO_W-1:0] * nrm_in.bm[LO_W-1:0];
      ac_hh <= nrm_in.am[NRM_W-1:LO_W] * nrm_in.cm[NRM_W-1:LO_W];
      ac_hl <= nrm_in.am[NRM_W-1:LO_W] * nrm_in.cm[LO_W-1:0];
      ac_lh <= nrm_in.am[LO_W-1:0] * nrm_in.cm[NRM_W-1:LO_W];
      ac_ll <= nrm_in.am[LO_W-1:0] * nrm_in.cm[LO_W-1:0];
    end
  end

  assign ac_mid = {1'b0, ac_hl} + {1'b0, ac_lh};

  always_ff @(posedge clk) begin
    if (en) begin
      n2  <= n1;
      bb  <= (PROD_W'(bb_hh) << (2 * LO_W)) + (PROD_W'(bb_hl) << (LO_W + 1))
             + PROD_W'(bb_ll);
      ac  <= (PROD_W'(ac_hh) << (2 * LO_W)) + (PROD_W'(ac_mid) << LO_W)
             + PROD_W'(ac_ll);
      add <= n1.na ^ n1.nc;
    end
  end

  // signed difference as magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= n2;
      if (add) begin
        dmag <= bb + ac;
        dneg <= 1'b0;
      end else if (bb >= ac) begin
        dmag <= bb - ac;
        dneg <= 1'b0;
      end else begin
        dmag <= ac - bb;
        dneg <= 1'b1;
      end
    end
  end

  assign limit     = PROD_W'({tol, {DISC_SHIFT{1'b0}}});
  assign near_zero = dmag <= limit;

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_out  <= n3;
      rad      <= (dneg || near_zero) ? '0 : dmag;
      extremum <= dneg && !near_zero;
    end
  end

endmodule

// ===== sv/quadratic_root_solver.sv =====
// top level of the quadratic root solver: sign fold, scaling, discriminant,
// square root and root quotients; depends on qrs_pkg, qrs_divider, qrs_isqrt, qrs_disc
//
// channel         valid        stall        payload
// coefficients    coef_valid   coef_stall   coef_const, coef_lin, coef_quad
// roots           root_valid   root_stall   root_status, root_low, root_high
// tolerance       disc_tolerance_we         disc_tolerance_wdata
//
// one request per cycle while no stalled result holds coef_stall high; the path runs through the bit-per-stage
// normalisation dividers, discriminant, square root and final root dividers
// a stall on the result freezes every stage at once, so nothing is lost or repeated
// reset clears the valid bits and sets the tolerance to one
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             coef_valid,
  output logic                             coef_stall,
  input  logic signed [COEF_WIDTH-1:0]     coef_const,
  input  logic signed [COEF_WIDTH-1:0]     coef_lin,
  input  logic signed [COEF_WIDTH-1:0]     coef_quad,
  output logic                             root_valid,
  input  logic                             root_stall,
  output logic [1:0]                       root_status,
  output logic signed [qrs_pkg::OUT_W-1:0] root_low,
  output logic signed [qrs_pkg::OUT_W-1:0] root_high,
  input  logic                             disc_tolerance_we,
  input  logic [qrs_pkg::TOL_W-1:0]        disc_tolerance_wdata
);
  import qrs_pkg::*;

  localparam int CW    = COEF_WIDTH;
  localparam int MAG_W = CW + 1;
  localparam int QW    = BD_W + FRAC_BITS;
  localparam int CMP_W = (QW > OUT_W) ? QW : OUT_W;

  logic             adv;
  logic [TOL_W-1:0] tol;

  assign adv        = !(root_valid && root_stall);
  assign coef_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_W'(1);
    end else if (disc_tolerance_we) begin
      tol <= disc_tolerance_wdata;
    end
  end

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] x);
    return x[CW-1] ? (~x + CW'(1)) : x;
  endfunction

  // sign fold and magnitudes
  logic             v1, v2;
  logic [MAG_W-1:0] ma1, mb1, mc1, ma2, mb2, mc2, amx2;
  logic             na1, nc1, na2, nc2, zero2;
  logic             flip;
  logic [MAG_W-1:0] amx;

  assign flip = coef_lin[CW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= coef_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma1 <= {mag(coef_quad), 1'b0};
      mb1 <= {1'b0, mag(coef_lin)};
      mc1 <= {mag(coef_const), 1'b0};
      na1 <= flip ? (!coef_quad[CW-1] && (coef_quad != '0)) : coef_quad[CW-1];
      nc1 <= flip ? (!coef_const[CW-1] && (coef_const != '0)) : coef_const[CW-1];
    end
  end

  always_comb begin
    amx = ma1;
    if (amx < mb1) amx = mb1;
    if (amx < mc1) amx = mc1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma2   <= ma1;
      mb2   <= mb1;
      mc2   <= mc1;
      amx2  <= amx;
      na2   <= na1;
      nc2   <= nc1;
      zero2 <= amx == '0;
    end
  end

  // scaling by the largest magnitude
  logic             va, vb, vc;
  logic [NRM_W-1:0] aq, bq, cq;
  logic             na3, nc3, zero3;

  qrs_divider #(.DEN_W(MAG_W), .QUO_W(NRM_W), .SIDE_W(1)) u_norm_a (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2),
    .rem_in(ma2 >> 1), .low_in({ma2[0], {NORM_BITS{1'b0}}}), .den(amx2),
    .side_in(na2), .out_valid(va), .quo(aq), .side_out(na3)
  );

  qrs_divider #(.DEN_W(MAG_W), .QUO_W(NRM_W), .SIDE_W(1)) u_norm_b (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2),
    .rem_in(mb2 >> 1), .low_in({mb2[0], {NORM_BITS{1'b0}}}), .den(amx2),
    .side_in(zero2), .out_valid(vb), .quo(bq), .side_out(zero3)
  );

  qrs_divider #(.DEN_W(MAG_W), .QUO_W(NRM_W), .SIDE_W(1)) u_norm_c (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2),
    .rem_in(mc2 >> 1), .low_in({mc2[0], {NORM_BITS{1'b0}}}), .den(amx2),
    .side_in(nc2), .out_valid(vc), .quo(cq), .side_out(nc3)
  );

  nrm_t nrm3;
  assign nrm3 = '{zero: zero3, na: na3, nc: nc3, am: aq, bm: bq, cm: cq};

  // discriminant
  logic              vd;
  logic [PROD_W-1:0] rad;
  logic              extr_d;
  nrm_t              nrm_d;

  qrs_disc u_disc (
    .clk(clk), .rst(rst), .en(adv), .in_valid(va && vb && vc),
    .nrm_in(nrm3), .tol(tol), .out_valid(vd), .rad(rad),
    .extremum(extr_d), .nrm_out(nrm_d)
  );

  // square root
  localparam int SQ_SIDE = $bits(nrm_t) + 1;
  logic               vs;
  logic [SQRT_W-1:0]  dis;
  logic [SQ_SIDE-1:0] sq_side;
  nrm_t               nrm_s;
  logic               extr_s;

  qrs_isqrt #(.RAD_W(PROD_W), .SIDE_W(SQ_SIDE)) u_isqrt (
    .clk(clk), .rst(rst), .en(adv), .in_valid(vd), .rad(rad),
    .side_in({extr_d, nrm_d}), .out_valid(vs), .root(dis), .side_out(sq_side)
  );

  assign {extr_s, nrm_s} = sq_side;

  // denominators and case flags
  // the ratio limit exceeds any scaled magnitude, so its tests reduce to zero tests
  logic             v3;
  logic [BD_W-1:0]  bdis, bdis3;
  logic [NRM_W-1:0] cm3, am3;
  ctl_t             ctl3;
  logic             neg1_3;

  assign bdis = BD_W'(nrm_s.bm) + BD_W'(dis);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bdis3         <= bdis;
      cm3           <= nrm_s.cm;
      am3           <= nrm_s.am;
      ctl3.kill     <= nrm_s.zero || ((nrm_s.cm != '0) && (bdis == '0));
      ctl3.extremum <= extr_s;
      ctl3.zden     <= bdis == '0;
      ctl3.single   <= (dis == '0) || (nrm_s.am == '0);
      ctl3.neg0     <= !nrm_s.nc && (nrm_s.cm != '0);
      neg1_3        <= !nrm_s.na && (nrm_s.am != '0);
    end
  end

  // root quotients
  logic             vq0, vq1;
  logic [QW-1:0]    q0, q1;
  logic [$bits(ctl_t)-1:0] ctl_q_bits;
  ctl_t             ctl_q;
  logic             neg1_q;

  qrs_divider #(.DEN_W(BD_W), .QUO_W(QW), .SIDE_W($bits(ctl_t))) u_div_low (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3),
    .rem_in('0), .low_in({BD_W'(cm3), {FRAC_BITS{1'b0}}}), .den(bdis3),
    .side_in(ctl3), .out_valid(vq0), .quo(q0), .side_out(ctl_q_bits)
  );

  qrs_divider #(.DEN_W(NRM_W), .QUO_W(QW), .SIDE_W(1)) u_div_high (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3),
    .rem_in('0), .low_in({bdis3, {FRAC_BITS{1'b0}}}), .den(am3),
    .side_in(neg1_3), .out_valid(vq1), .quo(q1), .side_out(neg1_q)
  );

  assign ctl_q = ctl_t'(ctl_q_bits);

  // signed roots and range checks
  localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << (OUT_W - 1);

  logic             v4;
  logic [CMP_W-1:0] q0e, q1e, s0, s1;
  logic             fit0, fit1;
  logic signed [OUT_W-1:0] r0_4, r1_4;
  logic             fit0_4, fit1_4;
  ctl_t             ctl4;

  assign q0e  = CMP_W'(q0);
  assign q1e  = CMP_W'(q1);
  assign s0   = ctl_q.neg0 ? (~q0e + CMP_W'(1)) : q0e;
  assign s1   = neg1_q ? (~q1e + CMP_W'(1)) : q1e;
  assign fit0 = ctl_q.neg0 ? (q0e <= LIM) : (q0e < LIM);
  assign fit1 = neg1_q ? (q1e <= LIM) : (q1e < LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= vq0 && vq1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4   <= ctl_q;
      r0_4   <= ctl_q.zden ? '0 : s0[OUT_W-1:0];
      fit0_4 <= ctl_q.zden || fit0;
      r1_4   <= s1[OUT_W-1:0];
      fit1_4 <= fit1;
    end
  end

  // result register
  status_t                 status_next;
  logic signed [OUT_W-1:0] low_next, high_next;

  always_comb begin
    status_next = STAT_NONE;
    low_next    = '0;
    high_next   = '0;
    priority if (ctl4.kill || !fit0_4) begin
      status_next = STAT_NONE;
    end else if (ctl4.zden || ctl4.single) begin
      status_next = ctl4.extremum ? STAT_EXTREMUM : STAT_ONE;
      low_next    = r0_4;
    end else if (!fit1_4) begin
      status_next = STAT_NONE;
    end else begin
      status_next = STAT_TWO;
      low_next    = (r0_4 > r1_4) ? r1_4 : r0_4;
      high_next   = (r0_4 > r1_4) ? r0_4 : r1_4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root_status <= status_next;
      root_low    <= low_next;
      root_high   <= high_next;
    end
  end

endmodule
